[design/spmq_pkg.sv]
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared sizes, status codes and microcode field types for the sorted
// priority message queue.
// ----------------------------------------------------------------------------
package spmq_pkg;

  localparam int DEPTH         = 16;
  localparam int PRIO_WIDTH    = 8;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int ADDR_W        = $clog2(DEPTH);
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int STEP_W        = 4;

  // item status
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_POPPED   = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // input opcode
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_POP    = 1'b1;

  // wait field
  localparam logic [1:0] W_NONE = 2'd0;
  localparam logic [1:0] W_ITEM = 2'd1;
  localparam logic [1:0] W_OUT  = 2'd2;

  // jump field
  localparam logic [1:0] J_NEXT   = 2'd0;
  localparam logic [1:0] J_ALWAYS = 2'd1;
  localparam logic [1:0] J_IF     = 2'd2;

  // condition select
  localparam logic [2:0] CD_POP      = 3'd0;
  localparam logic [2:0] CD_FULL     = 3'd1;
  localparam logic [2:0] CD_EMPTY    = 3'd2;
  localparam logic [2:0] CD_PTR_ZERO = 3'd3;
  localparam logic [2:0] CD_NOT_LESS = 3'd4;
  localparam logic [2:0] CD_PTR_END  = 3'd5;

  // memory address select
  localparam logic [1:0] A_ZERO   = 2'd0;
  localparam logic [1:0] A_PTR    = 2'd1;
  localparam logic [1:0] A_PTR_M1 = 2'd2;

  // pointer update
  localparam logic [2:0] P_HOLD  = 3'd0;
  localparam logic [2:0] P_COUNT = 3'd1;
  localparam logic [2:0] P_ONE   = 3'd2;
  localparam logic [2:0] P_DEC   = 3'd3;
  localparam logic [2:0] P_INC   = 3'd4;

  // count update
  localparam logic [1:0] N_HOLD = 2'd0;
  localparam logic [1:0] N_INC  = 2'd1;
  localparam logic [1:0] N_DEC  = 2'd2;

  typedef struct packed {
    logic [1:0]        wait_on;
    logic [1:0]        jump;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
    logic              rd_en;
    logic [1:0]        rd_addr;
    logic              wr_en;
    logic              wr_new;
    logic [1:0]        wr_addr;
    logic [2:0]        ptr_op;
    logic [1:0]        cnt_op;
    logic              load_in;
    logic              load_head;
    logic              emit;
    logic [1:0]        emit_status;
  } ctrl_t;

  typedef struct packed {
    logic item_valid;
    logic out_free;
    logic pop;
    logic full;
    logic empty;
    logic ptr_zero;
    logic not_less;
    logic ptr_end;
  } flags_t;

endpackage

[design/spmq_sequencer.sv]
// ----------------------------------------------------------------------------
// spmq_sequencer
// Step counter, microcode ROM and jump logic. One control word per step.
// ----------------------------------------------------------------------------
module spmq_sequencer (
  input  logic                   clk,
  input  logic                   rst,
  input  spmq_pkg::flags_t       flags,
  output spmq_pkg::ctrl_t        ctrl,
  output logic                   go
);

  localparam logic [spmq_pkg::STEP_W-1:0] S_IDLE      = 4'd0;
  localparam logic [spmq_pkg::STEP_W-1:0] S_INS_FULL  = 4'd1;
  localparam logic [spmq_pkg::STEP_W-1:0] S_INS_TEST  = 4'd2;
  localparam logic [spmq_pkg::STEP_W-1:0] S_INS_READ  = 4'd3;
  localparam logic [spmq_pkg::STEP_W-1:0] S_INS_CMP   = 4'd4;
  localparam logic [spmq_pkg::STEP_W-1:0] S_INS_SHIFT = 4'd5;
  localparam logic [spmq_pkg::STEP_W-1:0] S_INS_PLACE = 4'd6;
  localparam logic [spmq_pkg::STEP_W-1:0] S_INS_REJ   = 4'd7;
  localparam logic [spmq_pkg::STEP_W-1:0] S_POP_CHK   = 4'd8;
  localparam logic [spmq_pkg::STEP_W-1:0] S_POP_HEAD  = 4'd9;
  localparam logic [spmq_pkg::STEP_W-1:0] S_POP_CAP   = 4'd10;
  localparam logic [spmq_pkg::STEP_W-1:0] S_POP_TEST  = 4'd11;
  localparam logic [spmq_pkg::STEP_W-1:0] S_POP_READ  = 4'd12;
  localparam logic [spmq_pkg::STEP_W-1:0] S_POP_MOVE  = 4'd13;
  localparam logic [spmq_pkg::STEP_W-1:0] S_POP_DONE  = 4'd14;
  localparam logic [spmq_pkg::STEP_W-1:0] S_POP_EMPTY = 4'd15;

  function automatic spmq_pkg::ctrl_t ucode(input logic [spmq_pkg::STEP_W-1:0] s);
    spmq_pkg::ctrl_t c;
    c = '0;
    unique case (s)
      S_IDLE: begin
        c.wait_on = spmq_pkg::W_ITEM;
        c.load_in = 1'b1;
        c.ptr_op  = spmq_pkg::P_COUNT;
        c.jump    = spmq_pkg::J_IF;
        c.cond    = spmq_pkg::CD_POP;
        c.target  = S_POP_CHK;
      end
      S_INS_FULL: begin
        c.jump   = spmq_pkg::J_IF;
        c.cond   = spmq_pkg::CD_FULL;
        c.target = S_INS_REJ;
      end
      S_INS_TEST: begin
        c.jump   = spmq_pkg::J_IF;
        c.cond   = spmq_pkg::CD_PTR_ZERO;
        c.target = S_INS_PLACE;
      end
      S_INS_READ: begin
        c.rd_en   = 1'b1;
        c.rd_addr = spmq_pkg::A_PTR_M1;
      end
      S_INS_CMP: begin
        c.jump   = spmq_pkg::J_IF;
        c.cond   = spmq_pkg::CD_NOT_LESS;
        c.target = S_INS_PLACE;
      end
      S_INS_SHIFT: begin
        c.wr_en   = 1'b1;
        c.wr_addr = spmq_pkg::A_PTR;
        c.ptr_op  = spmq_pkg::P_DEC;
        c.jump    = spmq_pkg::J_ALWAYS;
        c.target  = S_INS_TEST;
      end
      S_INS_PLACE: begin
        c.wait_on     = spmq_pkg::W_OUT;
        c.wr_en       = 1'b1;
        c.wr_new      = 1'b1;
        c.wr_addr     = spmq_pkg::A_PTR;
        c.cnt_op      = spmq_pkg::N_INC;
        c.emit        = 1'b1;
        c.emit_status = spmq_pkg::ST_INSERTED;
        c.jump        = spmq_pkg::J_ALWAYS;
        c.target      = S_IDLE;
      end
      S_INS_REJ: begin
        c.wait_on     = spmq_pkg::W_OUT;
        c.emit        = 1'b1;
        c.emit_status = spmq_pkg::ST_FULL;
        c.jump        = spmq_pkg::J_ALWAYS;
        c.target      = S_IDLE;
      end
      S_POP_CHK: begin
        c.jump   = spmq_pkg::J_IF;
        c.cond   = spmq_pkg::CD_EMPTY;
        c.target = S_POP_EMPTY;
      end
      S_POP_HEAD: begin
        c.rd_en   = 1'b1;
        c.rd_addr = spmq_pkg::A_ZERO;
        c.ptr_op  = spmq_pkg::P_ONE;
      end
      S_POP_CAP: begin
        c.load_head = 1'b1;
      end
      S_POP_TEST: begin
        c.jump   = spmq_pkg::J_IF;
        c.cond   = spmq_pkg::CD_PTR_END;
        c.target = S_POP_DONE;
      end
      S_POP_READ: begin
        c.rd_en   = 1'b1;
        c.rd_addr = spmq_pkg::A_PTR;
      end
      S_POP_MOVE: begin
        c.wr_en   = 1'b1;
        c.wr_addr = spmq_pkg::A_PTR_M1;
        c.ptr_op  = spmq_pkg::P_INC;
        c.jump    = spmq_pkg::J_ALWAYS;
        c.target  = S_POP_TEST;
      end
      S_POP_DONE: begin
        c.wait_on     = spmq_pkg::W_OUT;
        c.cnt_op      = spmq_pkg::N_DEC;
        c.emit        = 1'b1;
        c.emit_status = spmq_pkg::ST_POPPED;
        c.jump        = spmq_pkg::J_ALWAYS;
        c.target      = S_IDLE;
      end
      S_POP_EMPTY: begin
        c.wait_on     = spmq_pkg::W_OUT;
        c.emit        = 1'b1;
        c.emit_status = spmq_pkg::ST_EMPTY;
        c.jump        = spmq_pkg::J_ALWAYS;
        c.target      = S_IDLE;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  logic [spmq_pkg::STEP_W-1:0] step;
  logic [spmq_pkg::STEP_W-1:0] step_next;
  logic                        cond_true;

  assign ctrl = ucode(step);

  always_comb begin
    unique case (ctrl.cond)
      spmq_pkg::CD_POP:      cond_true = flags.pop;
      spmq_pkg::CD_FULL:     cond_true = flags.full;
      spmq_pkg::CD_EMPTY:    cond_true = flags.empty;
      spmq_pkg::CD_PTR_ZERO: cond_true = flags.ptr_zero;
      spmq_pkg::CD_NOT_LESS: cond_true = flags.not_less;
      spmq_pkg::CD_PTR_END:  cond_true = flags.ptr_end;
      default:               cond_true = 1'b0;
    endcase
  end

  always_comb begin
    unique case (ctrl.wait_on)
      spmq_pkg::W_ITEM: go = flags.item_valid;
      spmq_pkg::W_OUT:  go = flags.out_free;
      default:          go = 1'b1;
    endcase
  end

  always_comb begin
    step_next = step;
    if (go) begin
      unique case (ctrl.jump)
        spmq_pkg::J_ALWAYS: step_next = ctrl.target;
        spmq_pkg::J_IF:     step_next = cond_true ? ctrl.target : step + 1'b1;
        default:            step_next = step + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  a_item_only_idle: assert property (@(posedge clk) disable iff (rst)
    (ctrl.wait_on == spmq_pkg::W_ITEM) |-> (step == S_IDLE))
    else $error("item wait outside idle step");

  a_emit_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit && go) |=> (step == S_IDLE))
    else $error("sequencer did not return to idle after result");

endmodule

[design/spmq_datapath.sv]
// ----------------------------------------------------------------------------
// spmq_datapath
// Slot memory, pointer and count registers, input latch and result register,
// all driven by the current control word.
// ----------------------------------------------------------------------------
module spmq_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  spmq_pkg::ctrl_t                     ctrl,
  input  logic                                go,
  input  logic                                in_valid,
  input  logic                                func,
  input  logic [spmq_pkg::PRIO_WIDTH-1:0]     entry_priority,
  input  logic [spmq_pkg::PAYLOAD_WIDTH-1:0]  entry_payload,
  input  logic                                out_stall,
  output spmq_pkg::flags_t                    flags,
  output logic                                out_valid,
  output logic [1:0]                          status,
  output logic [spmq_pkg::PRIO_WIDTH-1:0]     out_priority,
  output logic [spmq_pkg::PAYLOAD_WIDTH-1:0]  out_payload,
  output logic [spmq_pkg::CNT_W-1:0]          occupancy
);

  logic [spmq_pkg::PRIO_WIDTH-1:0]    slot_priority [spmq_pkg::DEPTH];
  logic [spmq_pkg::PAYLOAD_WIDTH-1:0] slot_payload  [spmq_pkg::DEPTH];

  logic [spmq_pkg::PRIO_WIDTH-1:0]    in_prio;
  logic [spmq_pkg::PAYLOAD_WIDTH-1:0] in_pay;
  logic [spmq_pkg::PRIO_WIDTH-1:0]    rd_prio;
  logic [spmq_pkg::PAYLOAD_WIDTH-1:0] rd_pay;
  logic [spmq_pkg::PRIO_WIDTH-1:0]    head_prio;
  logic [spmq_pkg::PAYLOAD_WIDTH-1:0] head_pay;
  logic [spmq_pkg::CNT_W-1:0]         ptr;
  logic [spmq_pkg::CNT_W-1:0]         ptr_next;
  logic [spmq_pkg::CNT_W-1:0]         ptr_m1;
  logic [spmq_pkg::CNT_W-1:0]         count;
  logic [spmq_pkg::CNT_W-1:0]         count_next;
  logic [spmq_pkg::ADDR_W-1:0]        rd_idx;
  logic [spmq_pkg::ADDR_W-1:0]        wr_idx;
  logic [spmq_pkg::PRIO_WIDTH-1:0]    wr_prio;
  logic [spmq_pkg::PAYLOAD_WIDTH-1:0] wr_pay;

  assign ptr_m1 = ptr - 1'b1;

  function automatic logic [spmq_pkg::ADDR_W-1:0] sel_addr(
    input logic [1:0]                 a,
    input logic [spmq_pkg::CNT_W-1:0] p,
    input logic [spmq_pkg::CNT_W-1:0] pm1
  );
    logic [spmq_pkg::ADDR_W-1:0] r;
    r = '0;
    unique case (a)
      spmq_pkg::A_PTR:    r = p[spmq_pkg::ADDR_W-1:0];
      spmq_pkg::A_PTR_M1: r = pm1[spmq_pkg::ADDR_W-1:0];
      default:            r = '0;
    endcase
    return r;
  endfunction

  assign rd_idx  = sel_addr(ctrl.rd_addr, ptr, ptr_m1);
  assign wr_idx  = sel_addr(ctrl.wr_addr, ptr, ptr_m1);
  assign wr_prio = ctrl.wr_new ? in_prio : rd_prio;
  assign wr_pay  = ctrl.wr_new ? in_pay  : rd_pay;

  always_ff @(posedge clk) begin
    if (go && ctrl.wr_en) begin
      slot_priority[wr_idx] <= wr_prio;
      slot_payload[wr_idx]  <= wr_pay;
    end
    if (go && ctrl.rd_en) begin
      rd_prio <= slot_priority[rd_idx];
      rd_pay  <= slot_payload[rd_idx];
    end
  end

  always_comb begin
    ptr_next = ptr;
    if (go) begin
      unique case (ctrl.ptr_op)
        spmq_pkg::P_COUNT: ptr_next = count;
        spmq_pkg::P_ONE:   ptr_next = spmq_pkg::CNT_W'(1);
        spmq_pkg::P_DEC:   ptr_next = ptr_m1;
        spmq_pkg::P_INC:   ptr_next = ptr + 1'b1;
        default:           ptr_next = ptr;
      endcase
    end
  end

  always_comb begin
    count_next = count;
    if (go) begin
      unique case (ctrl.cnt_op)
        spmq_pkg::N_INC: count_next = count + 1'b1;
        spmq_pkg::N_DEC: count_next = count - 1'b1;
        default:         count_next = count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
    end else begin
      count <= count_next;
      ptr   <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && ctrl.load_in) begin
      in_prio <= entry_priority;
      in_pay  <= entry_payload;
    end
    if (go && ctrl.load_head) begin
      head_prio <= rd_prio;
      head_pay  <= rd_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && ctrl.emit) begin
      status    <= ctrl.emit_status;
      occupancy <= count_next;
      if (ctrl.emit_status == spmq_pkg::ST_POPPED) begin
        out_priority <= head_prio;
        out_payload  <= head_pay;
      end else begin
        out_priority <= '0;
        out_payload  <= '0;
      end
    end
  end

  assign flags.item_valid = in_valid;
  assign flags.out_free   = !out_valid || !out_stall;
  assign flags.pop        = (func == spmq_pkg::FUNC_POP);
  assign flags.full       = (count == spmq_pkg::CNT_W'(spmq_pkg::DEPTH));
  assign flags.empty      = (count == '0);
  assign flags.ptr_zero   = (ptr == '0);
  assign flags.not_less   = !(rd_prio < in_prio);
  assign flags.ptr_end    = (ptr >= count);

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= spmq_pkg::CNT_W'(spmq_pkg::DEPTH))
    else $error("occupancy above depth");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    (go && ctrl.emit && ctrl.emit_status == spmq_pkg::ST_POPPED) |-> (count != '0))
    else $error("pop result from empty queue");

  a_no_pop_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != spmq_pkg::ST_POPPED) |-> (out_priority == '0 && out_payload == '0))
    else $error("nonzero entry on a result without pop");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (go && ctrl.wr_en) |-> (ptr < spmq_pkg::CNT_W'(spmq_pkg::DEPTH) || ctrl.wr_addr == spmq_pkg::A_PTR_M1))
    else $error("slot write beyond depth");

endmodule

[design/sorted_priority_message_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_message_queue
// Bounded priority queue kept sorted in a slot memory, highest priority in
// slot 0, equal priorities in arrival order. A microcoded sequencer walks the
// slot memory one entry at a time for inserts and pops.
//
//   channel | ports                                     | handshake
//   --------+-------------------------------------------+--------------------
//   in      | func, entry_priority, entry_payload       | in_valid / in_stall
//   out     | status, out_priority, out_payload,        | out_valid/out_stall
//           | occupancy                                 |
//
// One microcode step per cycle unless a step waits on an item or output;
// the slot memory's registered read sets the pace. Insert: idle, full
// check, then test, read, compare and shift per entry, then place; a full
// queue goes to reject. Pop: idle, empty check, head read and capture,
// then test, read and move per entry, then done; an empty queue goes to empty.
// rst clears the step counter, count and result valid; slots need no clearing.
// A stalled result holds the sequencer in its next result step; the next item is
// taken while the result waits to be taken.
// ----------------------------------------------------------------------------
module sorted_priority_message_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic [spmq_pkg::PRIO_WIDTH-1:0]     entry_priority,
  input  logic [spmq_pkg::PAYLOAD_WIDTH-1:0]  entry_payload,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic [spmq_pkg::PRIO_WIDTH-1:0]     out_priority,
  output logic [spmq_pkg::PAYLOAD_WIDTH-1:0]  out_payload,
  output logic [spmq_pkg::CNT_W-1:0]          occupancy
);

  spmq_pkg::ctrl_t  ctrl;
  spmq_pkg::flags_t flags;
  logic             go;

  assign in_stall = (ctrl.wait_on != spmq_pkg::W_ITEM);

  spmq_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl),
    .go    (go)
  );

  spmq_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .go             (go),
    .in_valid       (in_valid),
    .func           (func),
    .entry_priority (entry_priority),
    .entry_payload  (entry_payload),
    .out_stall      (out_stall),
    .flags          (flags),
    .out_valid      (out_valid),
    .status         (status),
    .out_priority   (out_priority),
    .out_payload    (out_payload),
    .occupancy      (occupancy)
  );

endmodule
